// ===== hw/rtl/natural_log_approx_f64_core_macros.svh =====
// ----------------------------------------------------------------------------
// natural_log_approx_f64_core assertion macros
// Shared concurrent check forms, clocked on aclk and quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef NATURAL_LOG_APPROX_F64_CORE_MACROS_SVH
`define NATURAL_LOG_APPROX_F64_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define NLA_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define NLA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nla_pkg.sv =====
// ----------------------------------------------------------------------------
// nla_pkg
// Shared types, constants and helpers of the approximate natural log core.
// ----------------------------------------------------------------------------
package nla_pkg;

    // Offset taken from the biased exponent to form the integer part
    localparam logic [11:0] EXP_OFFSET = 12'h400;
    // Sign and exponent bits of 1.0
    localparam logic [11:0] ONE_SIGN_EXP = 12'h3ff;

    // Polynomial and scale constants as double encodings
    localparam logic [63:0] COEF3     = $realtobits(0.1582487026083649643648);
    localparam logic [63:0] COEF2     = $realtobits(1.0518750217176431040285);
    localparam logic [63:0] COEF1     = $realtobits(3.0478841468943745615315);
    localparam logic [63:0] COEF0     = $realtobits(1.1536207104929913242752);
    localparam logic [63:0] LN_TWO    = $realtobits(0.69314718055994530942);
    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [63:0] NEG_COEF2 = COEF2 ^ SIGN_MASK;
    localparam logic [63:0] NEG_COEF0 = COEF0 ^ SIGN_MASK;

    // Exponent code of the largest finite magnitude plus one
    localparam logic [10:0] EXP_SPECIAL = 11'h7ff;

    // Data that rides along with each request through the pipeline
    typedef struct packed {
        logic [51:0] frac;    // mantissa bits of the operand
        logic [63:0] ip_dbl;  // integer part as a double
        logic        last;    // end of vector
    } side_t;

    // Exact conversion of a small signed integer to a double
    function automatic logic [63:0] int_to_f64(input logic [11:0] ip);
        logic        sgn;
        logic [11:0] neg;
        logic [10:0] mag;
        logic [3:0]  msb;
        logic [51:0] frac;
        logic [10:0] exp_f;
        sgn  = ip[11];
        neg  = ~ip + 12'd1;
        mag  = sgn ? neg[10:0] : ip[10:0];
        msb  = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (mag[i]) begin
                msb = 4'(i);
            end
        end
        frac  = 52'(mag) << (6'd52 - 6'(msb));
        exp_f = 11'd1023 + 11'(msb);
        if (mag == 11'd0) begin
            return 64'd0;
        end
        return {sgn, exp_f, frac};
    endfunction

endpackage

// ===== hw/rtl/natural_log_approx_f64_core.sv =====
// ----------------------------------------------------------------------------
// natural_log_approx_f64_core
// Approximate natural log of a double: cubic polynomial of the mantissa in
// Horner order plus the exponent, scaled by ln 2, all as rounded doubles.
//
//   Channel  Dir  tdata (low bit up)     Other
//   s_       in   value_bits[63:0]       tlast = last_in
//   m_       out  log_bits[63:0]         tlast = last_out
//
// One request enters per cycle unless the output is stalled; the chain is
// four three-stage multipliers and four four-stage adders in turn.
// aresetn (synchronous) clears only the valid bits of the stages.
// A stalled output freezes the whole pipeline; s_tready follows it.
// ----------------------------------------------------------------------------
`include "natural_log_approx_f64_core_macros.svh"

module natural_log_approx_f64_core import nla_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value_bits
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] log_bits
    output logic        m_tlast
);

    logic        en;
    logic [11:0] ip;
    side_t       side0;

    // Advance the pipeline unless the output holds an untaken result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Split the request into integer part and mantissa
    always_comb begin
        ip           = {1'b0, s_tdata[62:52]} - EXP_OFFSET;
        side0.frac   = s_tdata[51:0];
        side0.ip_dbl = int_to_f64(ip);
        side0.last   = s_tlast;
    end

    logic        v1, v2, v3, v4, v5, v6, v7, v8;
    logic [63:0] r1, r2, r3, r4, r5, r6, r7, r8;
    side_t       sd1, sd2, sd3, sd4, sd5, sd6, sd7, sd8;

    // C3 * m
    nla_fmul u_mul1 (
        .aclk, .aresetn, .en,
        .in_valid(s_tvalid && s_tready), .in_a(COEF3),
        .in_b({ONE_SIGN_EXP, side0.frac}), .in_side(side0),
        .out_valid(v1), .out_res(r1), .out_side(sd1)
    );

    // - C2
    nla_fadd u_add2 (
        .aclk, .aresetn, .en,
        .in_valid(v1), .in_a(r1), .in_b(NEG_COEF2), .in_side(sd1),
        .out_valid(v2), .out_res(r2), .out_side(sd2)
    );

    // * m
    nla_fmul u_mul3 (
        .aclk, .aresetn, .en,
        .in_valid(v2), .in_a(r2), .in_b({ONE_SIGN_EXP, sd2.frac}), .in_side(sd2),
        .out_valid(v3), .out_res(r3), .out_side(sd3)
    );

    // + C1
    nla_fadd u_add4 (
        .aclk, .aresetn, .en,
        .in_valid(v3), .in_a(r3), .in_b(COEF1), .in_side(sd3),
        .out_valid(v4), .out_res(r4), .out_side(sd4)
    );

    // * m
    nla_fmul u_mul5 (
        .aclk, .aresetn, .en,
        .in_valid(v4), .in_a(r4), .in_b({ONE_SIGN_EXP, sd4.frac}), .in_side(sd4),
        .out_valid(v5), .out_res(r5), .out_side(sd5)
    );

    // - C0
    nla_fadd u_add6 (
        .aclk, .aresetn, .en,
        .in_valid(v5), .in_a(r5), .in_b(NEG_COEF0), .in_side(sd5),
        .out_valid(v6), .out_res(r6), .out_side(sd6)
    );

    // + integer part
    nla_fadd u_add7 (
        .aclk, .aresetn, .en,
        .in_valid(v6), .in_a(sd6.ip_dbl), .in_b(r6), .in_side(sd6),
        .out_valid(v7), .out_res(r7), .out_side(sd7)
    );

    // * ln 2, last stage doubles as the output register
    nla_fmul u_mul8 (
        .aclk, .aresetn, .en,
        .in_valid(v7), .in_a(r7), .in_b(LN_TWO), .in_side(sd7),
        .out_valid(v8), .out_res(r8), .out_side(sd8)
    );

    assign m_tvalid = v8;
    assign m_tdata  = r8;
    assign m_tlast  = sd8.last;

    `NLA_CHECK_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken during output stall")
    `NLA_CHECK_NOW(a_result_finite, m_tvalid, m_tdata[62:52] != EXP_SPECIAL, "result is not finite")

endmodule

// ===== hw/rtl/nla_fmul.sv =====
// ----------------------------------------------------------------------------
// nla_fmul
// Three-stage double multiply, round to nearest even, for normal or zero
// operands; side data and valid travel with each request.
// ----------------------------------------------------------------------------
`include "natural_log_approx_f64_core_macros.svh"

module nla_fmul import nla_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_a,
    input  logic [63:0] in_b,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [63:0] out_res,
    output side_t       out_side
);

    // Stage 1: split significands into partial products
    logic [52:0]  ma, mb;
    logic         v1_reg, sign1_reg, zero1_reg;
    logic [12:0]  exp1_reg;
    logic [51:0]  pp_hh_reg;
    logic [52:0]  pp_hl_reg, pp_lh_reg;
    logic [53:0]  pp_ll_reg;
    side_t        side1_reg;

    assign ma = {1'b1, in_a[51:0]};
    assign mb = {1'b1, in_b[51:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= in_side;
            sign1_reg <= in_a[63] ^ in_b[63];
            zero1_reg <= (in_a[62:52] == 11'd0) || (in_b[62:52] == 11'd0);
            exp1_reg  <= {2'b00, in_a[62:52]} + {2'b00, in_b[62:52]} - 13'd1023;
            pp_hh_reg <= ma[52:27] * mb[52:27];
            pp_hl_reg <= 53'(ma[52:27]) * 53'(mb[26:0]);
            pp_lh_reg <= 53'(ma[26:0]) * 53'(mb[52:27]);
            pp_ll_reg <= ma[26:0] * mb[26:0];
        end
    end

    // Stage 2: sum partial products into the full product
    logic [105:0] prod_next;
    logic [105:0] prod2_reg;
    logic         v2_reg, sign2_reg, zero2_reg;
    logic [12:0]  exp2_reg;
    side_t        side2_reg;

    assign prod_next = (106'(pp_hh_reg) << 54)
                     + ((106'(pp_hl_reg) + 106'(pp_lh_reg)) << 27)
                     + 106'(pp_ll_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod2_reg <= prod_next;
            sign2_reg <= sign1_reg;
            zero2_reg <= zero1_reg;
            exp2_reg  <= exp1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: normalize and round
    logic [51:0] mant;
    logic        guard, sticky, inc;
    logic [12:0] exp_n;
    logic [62:0] mag_next;
    logic [63:0] res_next;
    logic        v3_reg;
    logic [63:0] res3_reg;
    side_t       side3_reg;

    always_comb begin
        if (prod2_reg[105]) begin
            mant   = prod2_reg[104:53];
            guard  = prod2_reg[52];
            sticky = |prod2_reg[51:0];
            exp_n  = exp2_reg + 13'd1;
        end else begin
            mant   = prod2_reg[103:52];
            guard  = prod2_reg[51];
            sticky = |prod2_reg[50:0];
            exp_n  = exp2_reg;
        end
        inc      = guard & (sticky | mant[0]);
        mag_next = {exp_n[10:0], mant} + 63'(inc);
        res_next = zero2_reg ? {sign2_reg, 63'd0} : {sign2_reg, mag_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res3_reg  <= res_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_res   = res3_reg;
    assign out_side  = side3_reg;

    `NLA_CHECK_NEXT(a_mul_stall_hold, !en, $stable(res3_reg) && $stable(v3_reg), "fmul moved while stalled")

endmodule

// ===== hw/rtl/nla_fadd.sv =====
// ----------------------------------------------------------------------------
// nla_fadd
// Four-stage double add, round to nearest even, for normal or zero operands:
// align, add, leading-zero count, normalize and round.
// ----------------------------------------------------------------------------
`include "natural_log_approx_f64_core_macros.svh"

module nla_fadd import nla_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_a,
    input  logic [63:0] in_b,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [63:0] out_res,
    output side_t       out_side
);

    // Stage 1: order by magnitude and align the smaller operand
    logic         a_big;
    logic [63:0]  xop, yop;
    logic [52:0]  mx, my;
    logic [10:0]  diff;
    logic [5:0]   shamt;
    logic [108:0] ext;
    logic         v1_reg, sign1_reg, sub1_reg;
    logic [10:0]  exp1_reg;
    logic [55:0]  wx1_reg, wy1_reg;
    side_t        side1_reg;

    always_comb begin
        a_big = in_a[62:0] >= in_b[62:0];
        xop   = a_big ? in_a : in_b;
        yop   = a_big ? in_b : in_a;
        mx    = {xop[62:52] != 11'd0, xop[51:0]};
        my    = {yop[62:52] != 11'd0, yop[51:0]};
        diff  = xop[62:52] - yop[62:52];
        shamt = (diff > 11'd63) ? 6'd63 : diff[5:0];
        ext   = {my, 56'd0} >> shamt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= in_side;
            sign1_reg <= xop[63];
            sub1_reg  <= in_a[63] ^ in_b[63];
            exp1_reg  <= xop[62:52];
            wx1_reg   <= {mx, 3'b000};
            wy1_reg   <= {ext[108:54], |ext[53:0]};
        end
    end

    // Stage 2: add or subtract magnitudes
    logic [56:0] sum_next;
    logic        v2_reg, sign2_reg, sub2_reg;
    logic [10:0] exp2_reg;
    logic [56:0] sum2_reg;
    side_t       side2_reg;

    assign sum_next = sub1_reg ? ({1'b0, wx1_reg} - {1'b0, wy1_reg})
                               : ({1'b0, wx1_reg} + {1'b0, wy1_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum2_reg  <= sum_next;
            sign2_reg <= sign1_reg;
            sub2_reg  <= sub1_reg;
            exp2_reg  <= exp1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: count leading zeros of the sum
    logic [5:0]  lz_next;
    logic        v3_reg, sign3_reg, zero3_reg;
    logic [5:0]  lz3_reg;
    logic [10:0] exp3_reg;
    logic [56:0] sum3_reg;
    side_t       side3_reg;

    always_comb begin
        lz_next = 6'd0;
        for (int i = 0; i < 57; i++) begin
            if (sum2_reg[i]) begin
                lz_next = 6'(56 - i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    // Exact cancellation gives +0
    always_ff @(posedge aclk) begin
        if (en) begin
            lz3_reg   <= lz_next;
            sum3_reg  <= sum2_reg;
            exp3_reg  <= exp2_reg;
            zero3_reg <= (sum2_reg == 57'd0);
            sign3_reg <= (sum2_reg == 57'd0 && sub2_reg) ? 1'b0 : sign2_reg;
            side3_reg <= side2_reg;
        end
    end

    // Stage 4: normalize and round
    logic [56:0] norm;
    logic [51:0] mant;
    logic        guard, sticky, inc;
    logic [11:0] exp_n;
    logic [62:0] mag_next;
    logic [63:0] res_next;
    logic        v4_reg;
    logic [63:0] res4_reg;
    side_t       side4_reg;

    always_comb begin
        norm     = sum3_reg << lz3_reg;
        mant     = norm[55:4];
        guard    = norm[3];
        sticky   = |norm[2:0];
        exp_n    = {1'b0, exp3_reg} + 12'd1 - 12'(lz3_reg);
        inc      = guard & (sticky | mant[0]);
        mag_next = {exp_n[10:0], mant} + 63'(inc);
        res_next = zero3_reg ? {sign3_reg, 63'd0} : {sign3_reg, mag_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res4_reg  <= res_next;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = res4_reg;
    assign out_side  = side4_reg;

    `NLA_CHECK_NEXT(a_add_stall_hold, !en, $stable(res4_reg) && $stable(v4_reg), "fadd moved while stalled")
    `NLA_CHECK_NEXT(a_add_valid_advance, en && v3_reg, v4_reg, "fadd dropped a request")

endmodule
